// ===== design/mlts_pkg.sv =====
// Package for the multi-level trail store: sizes, field layout, codes and shared types.
// Used by the top level, mlts_find and the bench; depends on nothing.
package mlts_pkg;

   localparam int MAX_LEVELS     = 64;
   localparam int LEVEL_CAPACITY = 256;
   localparam int MAIN_CAPACITY  = 4096;
   localparam int LIT_W          = 21;

   localparam int CMD_W      = 3;
   localparam int LVL_ARG_W  = 8;
   localparam int POS_W      = 13;
   localparam int RESULT_W   = 21;
   localparam int STATUS_W   = 2;

   localparam int LVL_IDX_W  = $clog2(MAX_LEVELS);
   localparam int LVL_CNT_W  = $clog2(MAX_LEVELS + 1);
   localparam int LCAP_W     = $clog2(LEVEL_CAPACITY + 1);
   localparam int LOFF_W     = $clog2(LEVEL_CAPACITY);
   localparam int MCAP_W     = $clog2(MAIN_CAPACITY + 1);
   localparam int MADDR_W    = $clog2(MAIN_CAPACITY);
   localparam int LEVEL_DEPTH = MAX_LEVELS * LEVEL_CAPACITY;
   localparam int LADDR_W    = LVL_IDX_W + LOFF_W;

   localparam int REQ_LVL_LSB  = 0;
   localparam int REQ_LIT_LSB  = LVL_ARG_W;
   localparam int REQ_POS_LSB  = LVL_ARG_W + LIT_W;
   localparam int REQ_DATA_W   = ((LVL_ARG_W + LIT_W + POS_W + 7) / 8) * 8;
   localparam int REQ_USER_W   = ((CMD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((RESULT_W + 7) / 8) * 8;
   localparam int RSP_USER_W   = ((STATUS_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN       = 3'd0,
      CMD_DROP       = 3'd1,
      CMD_PUSH       = 3'd2,
      CMD_SET_CURSOR = 3'd3,
      CMD_FIND       = 3'd4,
      CMD_SIZE       = 3'd5,
      CMD_CURSOR     = 3'd6,
      CMD_READ       = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [LCAP_W-1:0] cursor;
      logic [LCAP_W-1:0] size;
   } level_meta_type;

   typedef struct packed {
      logic                 found;
      logic [LVL_IDX_W-1:0] index;
   } find_result_type;

endpackage

// ===== design/multi_level_trail_store.sv =====
// Top level of the multi-level trail store: command decode, level bookkeeping, response register.
// Depends on mlts_pkg, mlts_ram (trail and level metadata memories) and mlts_find.
//
// Every command passes through idle and execute: the beat is accepted in idle while the addressed trail entry and
// level metadata (size, cursor) are read from synchronous RAM, and in the execute state the
// command is resolved, written back and loaded into the response register. A new request
// beat is taken only in idle, once the response register is empty or being drained, so a
// command is not accepted while the previous one executes. Find next resolves in execute
// from a per-level pending bitmask. The trail memories need no clearing pass after reset.
module multi_level_trail_store (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_data,      // multitrail_enable
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mlts_pkg::REQ_DATA_W-1:0]  req_tdata,     // level_arg, literal, position
   input  logic [mlts_pkg::REQ_USER_W-1:0]  req_tuser,     // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mlts_pkg::RSP_DATA_W-1:0]  rsp_tdata,     // result_value
   output logic [mlts_pkg::RSP_USER_W-1:0]  rsp_tuser      // status
);

   mlts_pkg::state_type               state_ff, state_in;
   mlts_pkg::cmd_type                 cmd_ff;
   logic [mlts_pkg::LVL_ARG_W-1:0]    lvl_ff;
   logic [mlts_pkg::LIT_W-1:0]        lit_ff;
   logic [mlts_pkg::POS_W-1:0]        pos_ff;
   logic                              mode_ff;
   logic [mlts_pkg::LVL_CNT_W-1:0]    level_count_ff, level_count_in;
   logic [mlts_pkg::MCAP_W-1:0]       main_size_ff, main_size_in;
   logic [mlts_pkg::POS_W-1:0]        main_cursor_ff, main_cursor_in;
   logic [mlts_pkg::MAX_LEVELS-1:0]   pending_ff, pending_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mlts_pkg::RESULT_W-1:0]     rsp_value_ff, rsp_value_in;
   mlts_pkg::status_type              rsp_status_ff, rsp_status_in;

   logic                              req_fire;
   logic [mlts_pkg::LVL_ARG_W-1:0]    req_lvl;
   logic [mlts_pkg::POS_W-1:0]        req_pos;
   logic [mlts_pkg::LVL_IDX_W-1:0]    req_li;

   logic                              lvl_neg;
   logic                              lvl_zero;
   logic                              lvl_ok;
   logic                              use_main;
   logic [mlts_pkg::LVL_IDX_W-1:0]    li;
   logic [mlts_pkg::LVL_ARG_W-1:0]    find_start;
   mlts_pkg::find_result_type         find_res;

   logic                              main_we;
   logic [mlts_pkg::LIT_W-1:0]        main_rd;
   logic                              level_we;
   logic [mlts_pkg::LIT_W-1:0]        level_rd;
   logic                              meta_we;
   logic [mlts_pkg::LVL_IDX_W-1:0]    meta_waddr;
   mlts_pkg::level_meta_type          meta_wdata;
   mlts_pkg::level_meta_type          meta_rd;
   logic [mlts_pkg::LCAP_W-1:0]       meta_size_inc;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;
   assign req_lvl   = req_tdata[mlts_pkg::REQ_LVL_LSB +: mlts_pkg::LVL_ARG_W];
   assign req_pos   = req_tdata[mlts_pkg::REQ_POS_LSB +: mlts_pkg::POS_W];
   assign req_li    = mlts_pkg::LVL_IDX_W'(req_lvl - mlts_pkg::LVL_ARG_W'(1));

   assign lvl_neg    = lvl_ff[mlts_pkg::LVL_ARG_W-1];
   assign lvl_zero   = (lvl_ff == '0);
   assign lvl_ok     = !lvl_neg && !lvl_zero
                       && (lvl_ff <= mlts_pkg::LVL_ARG_W'(level_count_ff));
   assign use_main   = !mode_ff || lvl_zero;
   assign li         = mlts_pkg::LVL_IDX_W'(lvl_ff - mlts_pkg::LVL_ARG_W'(1));
   assign find_start = lvl_neg ? '0 : lvl_ff;
   assign meta_size_inc = meta_rd.size + mlts_pkg::LCAP_W'(1);

   mlts_ram #(
      .Width (mlts_pkg::LIT_W),
      .Depth (mlts_pkg::MAIN_CAPACITY)
   ) u_main_ram (
      .clock   (clock),
      .wr_en   (main_we),
      .wr_addr (main_size_ff[mlts_pkg::MADDR_W-1:0]),
      .wr_data (lit_ff),
      .rd_en   (req_fire),
      .rd_addr (req_pos[mlts_pkg::MADDR_W-1:0]),
      .rd_data (main_rd)
   );

   mlts_ram #(
      .Width (mlts_pkg::LIT_W),
      .Depth (mlts_pkg::LEVEL_DEPTH)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (level_we),
      .wr_addr ({li, meta_rd.size[mlts_pkg::LOFF_W-1:0]}),
      .wr_data (lit_ff),
      .rd_en   (req_fire),
      .rd_addr ({req_li, req_pos[mlts_pkg::LOFF_W-1:0]}),
      .rd_data (level_rd)
   );

   mlts_ram #(
      .Width ($bits(mlts_pkg::level_meta_type)),
      .Depth (mlts_pkg::MAX_LEVELS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_en   (req_fire),
      .rd_addr (req_li),
      .rd_data (meta_rd)
   );

   mlts_find u_find (
      .pending (pending_ff),
      .start   (find_start),
      .count   (level_count_ff),
      .result  (find_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mlts_pkg::ST_IDLE;
         mode_ff        <= 1'b0;
         level_count_ff <= '0;
         main_size_ff   <= '0;
         main_cursor_ff <= '0;
         pending_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         level_count_ff <= level_count_in;
         main_size_ff   <= main_size_in;
         main_cursor_ff <= main_cursor_in;
         pending_ff     <= pending_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      if (req_fire) begin
         cmd_ff <= mlts_pkg::cmd_type'(req_tuser[mlts_pkg::CMD_W-1:0]);
         lvl_ff <= req_lvl;
         lit_ff <= req_tdata[mlts_pkg::REQ_LIT_LSB +: mlts_pkg::LIT_W];
         pos_ff <= req_pos;
      end
   end

   always_comb begin
      state_in       = state_ff;
      level_count_in = level_count_ff;
      main_size_in   = main_size_ff;
      main_cursor_in = main_cursor_ff;
      pending_in     = pending_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      req_tready     = 1'b0;
      main_we        = 1'b0;
      level_we       = 1'b0;
      meta_we        = 1'b0;
      meta_waddr     = li;
      meta_wdata     = meta_rd;

      case (state_ff)
         mlts_pkg::ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_tvalid && req_tready) begin
               state_in = mlts_pkg::ST_EXEC;
            end
         end
         mlts_pkg::ST_EXEC: begin
            state_in      = mlts_pkg::ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_value_in  = '0;
            rsp_status_in = mlts_pkg::STATUS_OK;
            case (cmd_ff)
               mlts_pkg::CMD_OPEN: begin
                  if (level_count_ff >= mlts_pkg::LVL_CNT_W'(mlts_pkg::MAX_LEVELS)) begin
                     rsp_status_in = mlts_pkg::STATUS_FULL;
                  end else begin
                     meta_we    = 1'b1;
                     meta_waddr = level_count_ff[mlts_pkg::LVL_IDX_W-1:0];
                     meta_wdata = '0;
                     pending_in[level_count_ff[mlts_pkg::LVL_IDX_W-1:0]] = 1'b0;
                     level_count_in = level_count_ff + mlts_pkg::LVL_CNT_W'(1);
                  end
               end
               mlts_pkg::CMD_DROP: begin
                  if (lvl_neg) begin
                     rsp_status_in = mlts_pkg::STATUS_RANGE;
                  end else if (lvl_ff < mlts_pkg::LVL_ARG_W'(level_count_ff)) begin
                     level_count_in = mlts_pkg::LVL_CNT_W'(lvl_ff);
                  end
               end
               mlts_pkg::CMD_FIND: begin
                  if (!mode_ff) begin
                     rsp_value_in = (main_cursor_ff == main_size_ff) ? '1 : '0;
                  end else if (lvl_ff == '1 && main_cursor_ff < main_size_ff) begin
                     rsp_value_in = '0;
                  end else if (find_res.found) begin
                     rsp_value_in = mlts_pkg::RESULT_W'(find_res.index)
                                    + mlts_pkg::RESULT_W'(1);
                  end else begin
                     rsp_value_in = '1;
                  end
               end
               default: begin
                  if (cmd_ff == mlts_pkg::CMD_CURSOR && lvl_neg) begin
                     rsp_value_in = '0;
                  end else if (!use_main && !lvl_ok) begin
                     rsp_status_in = mlts_pkg::STATUS_RANGE;
                  end else begin
                     case (cmd_ff)
                        mlts_pkg::CMD_PUSH: begin
                           if (use_main) begin
                              if (main_size_ff >=
                                  mlts_pkg::MCAP_W'(mlts_pkg::MAIN_CAPACITY)) begin
                                 rsp_status_in = mlts_pkg::STATUS_FULL;
                              end else begin
                                 main_we      = 1'b1;
                                 main_size_in = main_size_ff + mlts_pkg::MCAP_W'(1);
                              end
                           end else if (meta_rd.size >=
                                        mlts_pkg::LCAP_W'(mlts_pkg::LEVEL_CAPACITY)) begin
                              rsp_status_in = mlts_pkg::STATUS_FULL;
                           end else begin
                              level_we        = 1'b1;
                              meta_we         = 1'b1;
                              meta_wdata.size = meta_size_inc;
                              pending_in[li]  = meta_rd.cursor < meta_size_inc;
                           end
                        end
                        mlts_pkg::CMD_SET_CURSOR: begin
                           if (use_main) begin
                              if (pos_ff > mlts_pkg::POS_W'(mlts_pkg::MAIN_CAPACITY)) begin
                                 rsp_status_in = mlts_pkg::STATUS_RANGE;
                              end else begin
                                 main_cursor_in = pos_ff;
                              end
                           end else if (pos_ff >
                                        mlts_pkg::POS_W'(mlts_pkg::LEVEL_CAPACITY)) begin
                              rsp_status_in = mlts_pkg::STATUS_RANGE;
                           end else begin
                              meta_we           = 1'b1;
                              meta_wdata.cursor = mlts_pkg::LCAP_W'(pos_ff);
                              pending_in[li]    =
                                 mlts_pkg::LCAP_W'(pos_ff) < meta_rd.size;
                           end
                        end
                        mlts_pkg::CMD_SIZE: begin
                           rsp_value_in = use_main ? mlts_pkg::RESULT_W'(main_size_ff)
                                                   : mlts_pkg::RESULT_W'(meta_rd.size);
                        end
                        mlts_pkg::CMD_CURSOR: begin
                           rsp_value_in = use_main ? mlts_pkg::RESULT_W'(main_cursor_ff)
                                                   : mlts_pkg::RESULT_W'(meta_rd.cursor);
                        end
                        mlts_pkg::CMD_READ: begin
                           if (use_main) begin
                              if (pos_ff >= mlts_pkg::POS_W'(main_size_ff)) begin
                                 rsp_status_in = mlts_pkg::STATUS_RANGE;
                              end else begin
                                 rsp_value_in = mlts_pkg::RESULT_W'(main_rd);
                              end
                           end else if (pos_ff >= mlts_pkg::POS_W'(meta_rd.size)) begin
                              rsp_status_in = mlts_pkg::STATUS_RANGE;
                           end else begin
                              rsp_value_in = mlts_pkg::RESULT_W'(level_rd);
                           end
                        end
                        default: begin
                           rsp_status_in = mlts_pkg::STATUS_OK;
                        end
                     endcase
                  end
               end
            endcase
         end
         default: begin
            state_in = mlts_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mlts_pkg::RSP_DATA_W'(rsp_value_ff);
   assign rsp_tuser  = mlts_pkg::RSP_USER_W'(rsp_status_ff);

   a_fire_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == mlts_pkg::ST_EXEC)
      else $error("accepted beat did not enter execute");

   a_exec_to_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == mlts_pkg::ST_EXEC |=> rsp_valid_ff && state_ff == mlts_pkg::ST_IDLE)
      else $error("execute cycle did not load the response register");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      level_count_ff <= mlts_pkg::LVL_CNT_W'(mlts_pkg::MAX_LEVELS)
      && main_size_ff <= mlts_pkg::MCAP_W'(mlts_pkg::MAIN_CAPACITY))
      else $error("level count or main size beyond its limit");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != mlts_pkg::STATUS_OK |-> rsp_value_ff == '0)
      else $error("failed command returned a nonzero value");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == mlts_pkg::ST_IDLE |-> !main_we && !level_we && !meta_we)
      else $error("memory write outside execute");

endmodule

// ===== design/mlts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; no package dependency.
module mlts_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mlts_find.sv =====
// Next-pending-level search over the per-level pending bitmask.
// Depends on mlts_pkg for sizes and the search result type.
module mlts_find (
   input  logic [mlts_pkg::MAX_LEVELS-1:0] pending,
   input  logic [mlts_pkg::LVL_ARG_W-1:0]  start,
   input  logic [mlts_pkg::LVL_CNT_W-1:0]  count,
   output mlts_pkg::find_result_type       result
);

   always_comb begin
      result.found = 1'b0;
      result.index = '0;
      for (int l = mlts_pkg::MAX_LEVELS - 1; l >= 0; l--) begin
         if (pending[l] && (l >= int'(start)) && (l < int'(count))) begin
            result.found = 1'b1;
            result.index = mlts_pkg::LVL_IDX_W'(l);
         end
      end
   end

endmodule

// ===== test/multi_level_trail_store_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multi_level_trail_store: directed table, then random command streams.
// Holds its own model of the main and per-level trails; depends on mlts_pkg and the block RTL.
module multi_level_trail_store_test;

   localparam int STALL_LIMIT = 2000;

   typedef logic signed [mlts_pkg::LVL_ARG_W-1:0] level_arg_type;
   typedef logic [mlts_pkg::LIT_W-1:0]            literal_type;
   typedef logic [mlts_pkg::POS_W-1:0]            position_type;
   typedef logic [mlts_pkg::RESULT_W-1:0]         value_type;

   typedef struct packed {
      value_type            value;
      mlts_pkg::status_type status;
   } reply_type;

   typedef struct {
      bit                   cfg;
      bit                   mode;
      mlts_pkg::cmd_type    cmd;
      level_arg_type        lvl;
      literal_type          lit;
      position_type         pos;
      bit                   typed;
      value_type            value;
      mlts_pkg::status_type status;
   } table_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic                             csr_data = 1'b0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [mlts_pkg::REQ_DATA_W-1:0]  req_tdata = '0;   // level_arg, literal, position
   logic [mlts_pkg::REQ_USER_W-1:0]  req_tuser = '0;   // command
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [mlts_pkg::RSP_DATA_W-1:0]  rsp_tdata;        // result_value
   logic [mlts_pkg::RSP_USER_W-1:0]  rsp_tuser;        // status

   // trail model state
   literal_type main_mem   [mlts_pkg::MAIN_CAPACITY];
   literal_type level_mem  [mlts_pkg::LEVEL_DEPTH];
   int          lvl_size   [mlts_pkg::MAX_LEVELS];
   int          lvl_cursor [mlts_pkg::MAX_LEVELS];
   int          main_size = 0;
   int          main_cursor = 0;
   int          open_levels = 0;
   bit          mt_mode = 1'b0;

   reply_type     awaited_replies[$];
   table_row_type directed_rows[$];

   int send_idle = 31;
   int rcv_idle = 64;
   int quiet_cycles = 0;
   int errors = 0;
   int beats_sent = 0;
   int replies_checked = 0;
   int mode_writes = 0;
   int flags_full = 0;
   int flags_range = 0;

   multi_level_trail_store uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic resolve_command(input mlts_pkg::cmd_type cmd, input level_arg_type lvl,
                                  input literal_type lit, input position_type pos,
                                  output value_type val, output mlts_pkg::status_type st);
      bit use_main, lvl_ok, done, found;
      int lv, li, l, fill;
      lv = int'(lvl);
      use_main = !mt_mode || lv == 0;
      lvl_ok = lv >= 1 && lv <= open_levels;
      li = lvl_ok ? lv - 1 : 0;
      val = '0;
      st = mlts_pkg::STATUS_OK;
      done = 1'b1;
      found = 1'b0;
      case (cmd)
         mlts_pkg::CMD_OPEN: begin
            if (open_levels >= mlts_pkg::MAX_LEVELS) begin
               st = mlts_pkg::STATUS_FULL;
            end else begin
               lvl_size[open_levels] = 0;
               lvl_cursor[open_levels] = 0;
               open_levels++;
            end
         end
         mlts_pkg::CMD_DROP: begin
            if (lv < 0) st = mlts_pkg::STATUS_RANGE;
            else if (lv < open_levels) open_levels = lv;
         end
         mlts_pkg::CMD_FIND: begin
            if (!mt_mode) begin
               val = (main_cursor == main_size) ? '1 : '0;
            end else if (lv == -1 && main_cursor < main_size) begin
               val = '0;
            end else begin
               val = '1;
               for (l = (lv < 0) ? 0 : lv; l < open_levels; l++) begin
                  if (!found && lvl_cursor[l] < lvl_size[l]) begin
                     found = 1'b1;
                     val = mlts_pkg::RESULT_W'(l + 1);
                  end
               end
            end
         end
         mlts_pkg::CMD_CURSOR: done = lv < 0;
         default: done = 1'b0;
      endcase
      if (!done) begin
         if (!use_main && !lvl_ok) begin
            st = mlts_pkg::STATUS_RANGE;
         end else begin
            fill = use_main ? main_size : lvl_size[li];
            case (cmd)
               mlts_pkg::CMD_PUSH: begin
                  if (use_main) begin
                     if (main_size >= mlts_pkg::MAIN_CAPACITY) begin
                        st = mlts_pkg::STATUS_FULL;
                     end else begin
                        main_mem[main_size] = lit;
                        main_size++;
                     end
                  end else if (lvl_size[li] >= mlts_pkg::LEVEL_CAPACITY) begin
                     st = mlts_pkg::STATUS_FULL;
                  end else begin
                     level_mem[li * mlts_pkg::LEVEL_CAPACITY + lvl_size[li]] = lit;
                     lvl_size[li]++;
                  end
               end
               mlts_pkg::CMD_SET_CURSOR: begin
                  if (int'(pos) > (use_main ? mlts_pkg::MAIN_CAPACITY
                                            : mlts_pkg::LEVEL_CAPACITY))
                     st = mlts_pkg::STATUS_RANGE;
                  else if (use_main) main_cursor = int'(pos);
                  else lvl_cursor[li] = int'(pos);
               end
               mlts_pkg::CMD_SIZE: val = mlts_pkg::RESULT_W'(fill);
               mlts_pkg::CMD_CURSOR:
                  val = mlts_pkg::RESULT_W'(use_main ? main_cursor : lvl_cursor[li]);
               mlts_pkg::CMD_READ: begin
                  if (int'(pos) >= fill) st = mlts_pkg::STATUS_RANGE;
                  else if (use_main) val = main_mem[pos];
                  else val = level_mem[li * mlts_pkg::LEVEL_CAPACITY + int'(pos)];
               end
               default: ;
            endcase
         end
      end
      if (st == mlts_pkg::STATUS_FULL) flags_full++;
      if (st == mlts_pkg::STATUS_RANGE) flags_range++;
   endtask

   function automatic int trail_fill(input level_arg_type lvl);
      int lv;
      lv = int'(lvl);
      if (!mt_mode || lv == 0) return main_size;
      if (lv >= 1 && lv <= open_levels) return lvl_size[lv - 1];
      return 0;
   endfunction

   function automatic table_row_type row_of(input bit cfg, input bit mode,
                                            input mlts_pkg::cmd_type cmd,
                                            input logic [mlts_pkg::LVL_ARG_W-1:0] lvl,
                                            input literal_type lit,
                                            input position_type pos, input bit typed,
                                            input value_type value,
                                            input mlts_pkg::status_type status);
      table_row_type r;
      r.cfg = cfg;
      r.mode = mode;
      r.cmd = cmd;
      r.lvl = lvl;
      r.lit = lit;
      r.pos = pos;
      r.typed = typed;
      r.value = value;
      r.status = status;
      return r;
   endfunction

   task automatic append_row(input table_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endtask

   task automatic issue_command(input mlts_pkg::cmd_type cmd, input level_arg_type lvl,
                                input literal_type lit, input position_type pos,
                                input bit typed, input value_type tval,
                                input mlts_pkg::status_type tst);
      reply_type r;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mlts_pkg::REQ_USER_W'(cmd);
      req_tdata <= mlts_pkg::REQ_DATA_W'({pos, lit, lvl});
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      resolve_command(cmd, lvl, lit, pos, r.value, r.status);
      if (typed) begin
         r.value = tval;
         r.status = tst;
      end
      awaited_replies.insert(awaited_replies.size(), r);
      beats_sent++;
   endtask

   task automatic send_cmd(input mlts_pkg::cmd_type cmd, input level_arg_type lvl,
                           input literal_type lit, input position_type pos);
      issue_command(cmd, lvl, lit, pos, 1'b0, '0, mlts_pkg::STATUS_OK);
   endtask

   task automatic wait_drained();
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input bit mode);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= mode;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      mt_mode = mode;
      mode_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic draw_command(output mlts_pkg::cmd_type cmd, output level_arg_type lvl,
                               output literal_type lit, output position_type pos);
      int pick, fill, cap;
      pick = $urandom_range(99);
      if (pick < 10) cmd = mlts_pkg::CMD_OPEN;
      else if (pick < 16) cmd = mlts_pkg::CMD_DROP;
      else if (pick < 46) cmd = mlts_pkg::CMD_PUSH;
      else if (pick < 60) cmd = mlts_pkg::CMD_SET_CURSOR;
      else if (pick < 74) cmd = mlts_pkg::CMD_FIND;
      else if (pick < 82) cmd = mlts_pkg::CMD_SIZE;
      else if (pick < 90) cmd = mlts_pkg::CMD_CURSOR;
      else cmd = mlts_pkg::CMD_READ;
      case ($urandom_range(9))
         0: lvl = mlts_pkg::LVL_ARG_W'($urandom);
         1: lvl = ($urandom_range(1) == 0) ? '1 : mlts_pkg::LVL_ARG_W'(open_levels + 1);
         2: lvl = '0;
         default: lvl = (open_levels == 0) ? '0
                                           : mlts_pkg::LVL_ARG_W'($urandom_range(open_levels, 1));
      endcase
      if (cmd == mlts_pkg::CMD_FIND && $urandom_range(2) == 0) lvl = '1;
      lit = mlts_pkg::LIT_W'($urandom);
      fill = trail_fill(lvl);
      cap = (!mt_mode || lvl == 0) ? mlts_pkg::MAIN_CAPACITY : mlts_pkg::LEVEL_CAPACITY;
      case ($urandom_range(9))
         0: pos = mlts_pkg::POS_W'($urandom);
         1: pos = mlts_pkg::POS_W'(cap + int'($urandom_range(1)));
         2, 3: pos = mlts_pkg::POS_W'(fill);
         default: pos = (fill == 0) ? '0 : mlts_pkg::POS_W'($urandom_range(fill - 1));
      endcase
   endtask

   // sample outputs, drive receiver stalls, check replies
   always @(posedge clock) begin
      reply_type want;
      rsp_tready <= ($urandom_range(99) >= rcv_idle);
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready) ||
          (csr_valid && csr_ready === 1'b1)) quiet_cycles = 0;
      else quiet_cycles++;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (awaited_replies.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("reply with none awaited: value %h status %0d",
                        rsp_tdata[mlts_pkg::RESULT_W-1:0], rsp_tuser[mlts_pkg::STATUS_W-1:0]);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_tdata[mlts_pkg::RESULT_W-1:0] !== want.value ||
                rsp_tuser[mlts_pkg::STATUS_W-1:0] !== want.status) begin
               errors++;
               if (errors <= 10)
                  $display("reply %0d: expected value %h status %0d, got %h status %0d",
                           replies_checked, want.value, want.status,
                           rsp_tdata[mlts_pkg::RESULT_W-1:0],
                           rsp_tuser[mlts_pkg::STATUS_W-1:0]);
            end
            replies_checked++;
         end
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("multi_level_trail_store_test: done, errors");
      $finish;
   end

   initial begin
      mlts_pkg::cmd_type cmd;
      level_arg_type     lvl;
      literal_type       lit;
      position_type      pos;
      int                phase, seg, n, tgt;
      bit                mode;

      // mode off after reset
      append_row(row_of(0, 0, mlts_pkg::CMD_SIZE, 8'h00, '0, '0, 1, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_FIND, 8'hFF, '0, '0, 1, '1,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_READ, 8'h00, '0, '0, 1, '0,
                        mlts_pkg::STATUS_RANGE));
      append_row(row_of(0, 0, mlts_pkg::CMD_PUSH, 8'h05, 21'h0FFFFF, '0, 1, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_PUSH, 8'h00, 21'h100000, '0, 1, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_PUSH, 8'h00, '0, '0, 1, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_READ, 8'h00, '0, 13'd0, 0, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_READ, 8'h7F, '0, 13'd1, 0, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_SET_CURSOR, 8'h00, '0, 13'd4097, 1, '0,
                        mlts_pkg::STATUS_RANGE));
      append_row(row_of(0, 0, mlts_pkg::CMD_SET_CURSOR, 8'h00, '0, 13'd4096, 1, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_CURSOR, 8'hFF, '0, '0, 1, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_CURSOR, 8'h00, '0, '0, 0, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_FIND, 8'h00, '0, '0, 0, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_DROP, 8'h80, '0, '0, 1, '0,
                        mlts_pkg::STATUS_RANGE));
      append_row(row_of(0, 0, mlts_pkg::CMD_OPEN, 8'h00, '0, '0, 1, '0,
                        mlts_pkg::STATUS_OK));
      // per-level trails
      append_row(row_of(1, 1, mlts_pkg::CMD_OPEN, 8'h00, '0, '0, 0, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_PUSH, 8'h02, 21'h00001, '0, 1, '0,
                        mlts_pkg::STATUS_RANGE));
      append_row(row_of(0, 0, mlts_pkg::CMD_PUSH, 8'h01, -21'sd5, '0, 0, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_SET_CURSOR, 8'h01, '0, 13'd257, 1, '0,
                        mlts_pkg::STATUS_RANGE));
      append_row(row_of(0, 0, mlts_pkg::CMD_FIND, 8'hFF, '0, '0, 0, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_SET_CURSOR, 8'h00, '0, 13'd0, 1, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_FIND, 8'hFF, '0, '0, 0, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_FIND, 8'h01, '0, '0, 0, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_SIZE, 8'h7F, '0, '0, 1, '0,
                        mlts_pkg::STATUS_RANGE));
      append_row(row_of(0, 0, mlts_pkg::CMD_DROP, 8'h00, '0, '0, 1, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_READ, 8'h01, '0, 13'd0, 1, '0,
                        mlts_pkg::STATUS_RANGE));
      append_row(row_of(0, 0, mlts_pkg::CMD_OPEN, 8'h00, '0, '0, 1, '0,
                        mlts_pkg::STATUS_OK));
      append_row(row_of(0, 0, mlts_pkg::CMD_SIZE, 8'h01, '0, '0, 1, '0,
                        mlts_pkg::STATUS_OK));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg)
            write_mode(directed_rows[i].mode);
         else
            issue_command(directed_rows[i].cmd, directed_rows[i].lvl, directed_rows[i].lit,
                          directed_rows[i].pos, directed_rows[i].typed,
                          directed_rows[i].value, directed_rows[i].status);
      end

      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 31 : (phase == 1) ? 64 : 0;
         rcv_idle = (phase == 0) ? 64 : (phase == 1) ? 31 : 0;
         for (seg = 0; seg < 2; seg++) begin
            mode = seg[0] ^ (phase == 1);
            write_mode(mode);
            // open up to the level limit, then overflow
            if (mode) begin
               while (open_levels < mlts_pkg::MAX_LEVELS)
                  send_cmd(mlts_pkg::CMD_OPEN, '0, '0, '0);
               send_cmd(mlts_pkg::CMD_OPEN, '0, '0, '0);
               send_cmd(mlts_pkg::CMD_OPEN, '1, '0, '0);
            end
            for (n = 0; n < (mode ? 100 : 70); n++) begin
               // fill one level trail past capacity
               if (mode && phase == 0 && n == 50 && open_levels > 0) begin
                  tgt = $urandom_range(open_levels, 1);
                  while (lvl_size[tgt - 1] < mlts_pkg::LEVEL_CAPACITY)
                     send_cmd(mlts_pkg::CMD_PUSH, mlts_pkg::LVL_ARG_W'(tgt),
                              mlts_pkg::LIT_W'($urandom), mlts_pkg::POS_W'($urandom));
                  send_cmd(mlts_pkg::CMD_PUSH, mlts_pkg::LVL_ARG_W'(tgt),
                           mlts_pkg::LIT_W'($urandom), '0);
                  send_cmd(mlts_pkg::CMD_READ, mlts_pkg::LVL_ARG_W'(tgt), '0,
                           mlts_pkg::POS_W'(mlts_pkg::LEVEL_CAPACITY - 1));
                  send_cmd(mlts_pkg::CMD_SET_CURSOR, mlts_pkg::LVL_ARG_W'(tgt), '0,
                           mlts_pkg::POS_W'(mlts_pkg::LEVEL_CAPACITY));
                  send_cmd(mlts_pkg::CMD_FIND, '1, '0, '0);
               end
               draw_command(cmd, lvl, lit, pos);
               send_cmd(cmd, lvl, lit, pos);
            end
         end
      end

      write_mode(1'b0);
      send_cmd(mlts_pkg::CMD_READ, '0, '0, mlts_pkg::POS_W'(mlts_pkg::MAIN_CAPACITY - 1));
      send_cmd(mlts_pkg::CMD_SIZE, '0, '0, '0);
      send_cmd(mlts_pkg::CMD_FIND, '1, '0, '0);

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (awaited_replies.size() != 0) begin
         errors += awaited_replies.size();
         $display("%0d replies never arrived", awaited_replies.size());
      end

      $display("covered %0d command beats and %0d replies over %0d mode writes",
               beats_sent, replies_checked, mode_writes);
      $display("predicted %0d full/overflow and %0d out-of-range flags; %0d mismatches",
               flags_full, flags_range, errors);
      if (errors == 0)
         $display("multi_level_trail_store_test: done, clean");
      else
         $display("multi_level_trail_store_test: done, errors");
      $finish;
   end

endmodule
